// ===== design/dttl_pkg.sv =====
// Package for the DNS TTL ageing rewriter: parse phases, status codes,
// field lengths and the structures passed between the parser and the queue.
// No dependencies.
package dttl_pkg;

    // Parse phase of the message walker
    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_NAME     = 4'd1,
        PH_NAME_PTR = 4'd2,
        PH_QTAIL    = 4'd3,
        PH_FIXED    = 4'd4,
        PH_RDATA    = 4'd5,
        PH_DONE     = 4'd6
    } phase_t;

    // Message status reported with the final word
    typedef enum logic [1:0] {
        ST_FRESH     = 2'd0,
        ST_EXPIRED   = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    // Wire format lengths and codes
    localparam logic [3:0]  HEADER_LEN  = 4'd12;
    localparam logic [3:0]  FIXED_LEN   = 4'd10;
    localparam logic [3:0]  QTAIL_LEN   = 4'd4;
    localparam logic [3:0]  TTL_LAST    = 4'd7;
    localparam logic [3:0]  RDLEN_FIRST = 4'd8;
    localparam logic [7:0]  LABEL_LIMIT = 8'd64;
    localparam logic [1:0]  PTR_TAG     = 2'b11;
    localparam logic [15:0] TYPE_OPT    = 16'd41;

    // Most words one input word can cause
    localparam int MAX_RUN = 4;

    // Default depth of the result queue (power of two, at least 8)
    localparam int OUTQ_DEPTH_DEF = 8;

    // One input word as held in the input register
    typedef struct packed {
        logic [7:0]  pkt_byte;
        logic        pkt_last;
        logic [31:0] stored_time;
        logic [31:0] current_time;
    } item_t;

    // Up to four result bytes produced by one input word
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
        logic            msg_last;
        status_t         status;
    } bundle_t;

    // One queued result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       message_end;
        status_t    message_status;
    } word_t;

endpackage

// ===== design/dttl_in_if.sv =====
// Input channel of the DNS TTL ageing rewriter: valid/ready plus one message byte
// with its end marker and the two timestamps. No dependencies.
interface dttl_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pkt_byte;
    logic        pkt_last;
    logic [31:0] stored_time;
    logic [31:0] current_time;

    modport source (output valid, output pkt_byte, output pkt_last,
                    output stored_time, output current_time, input ready);
    modport sink   (input valid, input pkt_byte, input pkt_last,
                    input stored_time, input current_time, output ready);
endinterface

// ===== design/dttl_out_if.sv =====
// Result channel of the DNS TTL ageing rewriter: valid/ready plus one output
// byte with run and message markers and the message status. No dependencies.
interface dttl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;
    logic [1:0] message_status;

    modport source (output valid, output out_byte, output run_end,
                    output message_end, output message_status, input ready);
    modport sink   (input valid, input out_byte, input run_end,
                    input message_end, input message_status, output ready);
endinterface

// ===== design/dttl_parse.sv =====
// Input register and message walker: tracks header counts, names, fixed fields
// and rdata, ages TTLs and emits up to four bytes per word. Uses dttl_pkg.
module dttl_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dttl_pkg::item_t  in_item,
    output logic             in_ready,
    input  logic             space_ok,
    output dttl_pkg::bundle_t bundle
);
    import dttl_pkg::*;

    typedef struct packed {
        phase_t     phase;
        logic       in_q;
        logic [1:0] sec;
    } entry_t;

    // Pick the next question or record, skipping empty sections
    function automatic entry_t next_entry(input logic in_q, input logic [15:0] q_left,
                                          input logic [15:0] an_left,
                                          input logic [15:0] ns_left,
                                          input logic [15:0] ar_left,
                                          input logic [1:0] sec);
        entry_t      e;
        logic        found;
        logic [15:0] cnt;
        e.phase = PH_DONE;
        e.in_q  = in_q;
        e.sec   = sec;
        found   = 1'b0;
        cnt     = '0;
        if (in_q && q_left != 16'd0)
        begin
            e.phase = PH_NAME;
            found   = 1'b1;
        end
        else
        begin
            if (in_q)
            begin
                e.in_q = 1'b0;
                e.sec  = 2'd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (!found)
                begin
                    cnt = (e.sec == 2'd0) ? an_left : (e.sec == 2'd1) ? ns_left : ar_left;
                    if (cnt != 16'd0)
                    begin
                        e.phase = PH_NAME;
                        found   = 1'b1;
                    end
                    else if (e.sec >= 2'd2)
                    begin
                        e.phase = PH_DONE;
                        found   = 1'b1;
                    end
                    else
                    begin
                        e.sec = e.sec + 2'd1;
                    end
                end
            end
        end
        return e;
    endfunction

    item_t       item_reg;
    logic        item_valid_reg;
    logic        fire;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fo_reg, fo_next;
    logic        in_q_reg, in_q_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] an_reg, an_next;
    logic [15:0] ns_reg, ns_next;
    logic [15:0] ar_reg, ar_next;
    logic [1:0]  sec_reg, sec_next;
    logic [5:0]  label_reg, label_next;
    logic [15:0] rdata_reg, rdata_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        expired_reg, expired_next;
    logic        malformed_reg, malformed_next;

    logic [7:0]  b;
    logic [31:0] elapsed_calc;
    logic [31:0] ttl_shift;
    logic        ttl_expire;
    logic [31:0] ttl_aged;
    logic        do_next;
    logic        rec_done;
    entry_t      ent;

    // Input register: refills whenever the held word moves on
    assign fire     = item_valid_reg && space_ok;
    assign in_ready = !item_valid_reg || space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    // Datapath terms: elapsed time and TTL ageing
    assign b            = item_reg.pkt_byte;
    assign elapsed_calc = (item_reg.current_time > item_reg.stored_time)
                          ? item_reg.current_time - item_reg.stored_time : 32'd0;
    assign ttl_shift    = {ttl_reg[23:0], b};
    assign ttl_expire   = (ttl_shift <= 32'd1) || (elapsed_reg >= ttl_shift);
    assign ttl_aged     = ttl_expire ? 32'd1 : ttl_shift - elapsed_reg;

    // Walker next state and emitted bytes
    always_comb
    begin
        phase_next     = phase_reg;
        fo_next        = fo_reg;
        in_q_next      = in_q_reg;
        q_next         = q_reg;
        an_next        = an_reg;
        ns_next        = ns_reg;
        ar_next        = ar_reg;
        sec_next       = sec_reg;
        label_next     = label_reg;
        rdata_next     = rdata_reg;
        type_next      = type_reg;
        ttl_next       = ttl_reg;
        elapsed_next   = elapsed_reg;
        expired_next   = expired_reg;
        malformed_next = malformed_reg;
        do_next        = 1'b0;
        rec_done       = 1'b0;
        ent            = '{phase: PH_HEADER, in_q: 1'b0, sec: 2'd0};
        bundle         = '0;

        if (fire)
        begin
            bundle.bytes[0] = b;
            bundle.count    = 3'd1;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (fo_reg == 4'd0)
                    begin
                        elapsed_next = elapsed_calc;
                        q_next       = '0;
                        an_next      = '0;
                        ns_next      = '0;
                        ar_next      = '0;
                    end
                    case (fo_reg) inside
                        4'd4, 4'd5:   q_next  = {q_next[7:0], b};
                        4'd6, 4'd7:   an_next = {an_next[7:0], b};
                        4'd8, 4'd9:   ns_next = {ns_next[7:0], b};
                        4'd10, 4'd11: ar_next = {ar_next[7:0], b};
                        default:      ;
                    endcase
                    fo_next = fo_reg + 4'd1;
                    if (fo_next >= HEADER_LEN)
                    begin
                        in_q_next = 1'b1;
                        sec_next  = 2'd0;
                        do_next   = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    if (label_reg != 6'd0)
                    begin
                        label_next = label_reg - 6'd1;
                    end
                    else if (b == 8'd0)
                    begin
                        fo_next    = 4'd0;
                        phase_next = in_q_reg ? PH_QTAIL : PH_FIXED;
                    end
                    else if (b < LABEL_LIMIT)
                    begin
                        label_next = b[5:0];
                    end
                    else if (b[7:6] == PTR_TAG)
                    begin
                        phase_next = PH_NAME_PTR;
                    end
                    else
                    begin
                        malformed_next = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end
                PH_NAME_PTR:
                begin
                    fo_next    = 4'd0;
                    phase_next = in_q_reg ? PH_QTAIL : PH_FIXED;
                end
                PH_QTAIL:
                begin
                    fo_next = fo_reg + 4'd1;
                    if (fo_next >= QTAIL_LEN)
                    begin
                        q_next  = q_reg - 16'd1;
                        do_next = 1'b1;
                    end
                end
                PH_FIXED:
                begin
                    case (fo_reg) inside
                        4'd0, 4'd1:
                        begin
                            type_next = {type_reg[7:0], b};
                        end
                        4'd4, 4'd5, 4'd6, 4'd7:
                        begin
                            // TTL bytes are held; the fourth releases all four
                            ttl_next     = ttl_shift;
                            bundle.count = 3'd0;
                            if (fo_reg == TTL_LAST)
                            begin
                                if (type_reg != TYPE_OPT)
                                begin
                                    ttl_next = ttl_aged;
                                    if (ttl_expire && sec_reg == 2'd0)
                                    begin
                                        expired_next = 1'b1;
                                    end
                                end
                                bundle.bytes = {ttl_next[7:0], ttl_next[15:8],
                                                ttl_next[23:16], ttl_next[31:24]};
                                bundle.count = 3'd4;
                            end
                        end
                        default:
                        begin
                            if (fo_reg >= RDLEN_FIRST)
                            begin
                                rdata_next = {rdata_reg[7:0], b};
                            end
                        end
                    endcase
                    fo_next = fo_reg + 4'd1;
                    if (fo_next >= FIXED_LEN)
                    begin
                        fo_next = 4'd0;
                        if (rdata_next == 16'd0)
                        begin
                            rec_done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RDATA;
                        end
                    end
                end
                PH_RDATA:
                begin
                    rdata_next = rdata_reg - 16'd1;
                    if (rdata_next == 16'd0)
                    begin
                        rec_done = 1'b1;
                    end
                end
                default: ;
            endcase

            // Record finished: count it off its section
            if (rec_done)
            begin
                case (sec_reg)
                    2'd0:    an_next = an_reg - 16'd1;
                    2'd1:    ns_next = ns_reg - 16'd1;
                    default: ar_next = ar_reg - 16'd1;
                endcase
                do_next = 1'b1;
            end

            if (do_next)
            begin
                ent        = next_entry(in_q_next, q_next, an_next, ns_next, ar_next, sec_next);
                phase_next = ent.phase;
                in_q_next  = ent.in_q;
                sec_next   = ent.sec;
                fo_next    = 4'd0;
                label_next = 6'd0;
            end

            // Final byte: flush held TTL bytes, settle status, return to reset state
            if (item_reg.pkt_last)
            begin
                if (phase_next == PH_FIXED)
                begin
                    case (fo_next)
                        4'd5:
                        begin
                            bundle.bytes[0] = ttl_next[7:0];
                            bundle.bytes[1] = b;
                            bundle.count    = 3'd2;
                        end
                        4'd6:
                        begin
                            bundle.bytes[0] = ttl_next[15:8];
                            bundle.bytes[1] = ttl_next[7:0];
                            bundle.bytes[2] = b;
                            bundle.count    = 3'd3;
                        end
                        4'd7:
                        begin
                            bundle.bytes[0] = ttl_next[23:16];
                            bundle.bytes[1] = ttl_next[15:8];
                            bundle.bytes[2] = ttl_next[7:0];
                            bundle.bytes[3] = b;
                            bundle.count    = 3'd4;
                        end
                        default: ;
                    endcase
                end
                if (phase_next != PH_DONE)
                begin
                    malformed_next = 1'b1;
                end
                bundle.msg_last = 1'b1;
                bundle.status   = malformed_next ? ST_MALFORMED :
                                  expired_next   ? ST_EXPIRED   : ST_FRESH;

                phase_next     = PH_HEADER;
                fo_next        = 4'd0;
                in_q_next      = 1'b1;
                q_next         = '0;
                an_next        = '0;
                ns_next        = '0;
                ar_next        = '0;
                sec_next       = 2'd0;
                label_next     = 6'd0;
                rdata_next     = '0;
                type_next      = '0;
                ttl_next       = '0;
                elapsed_next   = '0;
                expired_next   = 1'b0;
                malformed_next = 1'b0;
            end
        end
    end

    // Walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fo_reg        <= 4'd0;
            in_q_reg      <= 1'b1;
            q_reg         <= '0;
            an_reg        <= '0;
            ns_reg        <= '0;
            ar_reg        <= '0;
            sec_reg       <= 2'd0;
            label_reg     <= 6'd0;
            rdata_reg     <= '0;
            type_reg      <= '0;
            ttl_reg       <= '0;
            elapsed_reg   <= '0;
            expired_reg   <= 1'b0;
            malformed_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fo_reg        <= fo_next;
            in_q_reg      <= in_q_next;
            q_reg         <= q_next;
            an_reg        <= an_next;
            ns_reg        <= ns_next;
            ar_reg        <= ar_next;
            sec_reg       <= sec_next;
            label_reg     <= label_next;
            rdata_reg     <= rdata_next;
            type_reg      <= type_next;
            ttl_reg       <= ttl_next;
            elapsed_reg   <= elapsed_next;
            expired_reg   <= expired_next;
            malformed_reg <= malformed_next;
        end
    end

    // A final byte always leaves the walker back at the start of a header
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.pkt_last |=> phase_reg == PH_HEADER && fo_reg == 4'd0 && in_q_reg)
        else $error("walker not returned to header after final byte");

    // Header bytes pass straight through, one word each
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_HEADER |-> bundle.count == 3'd1)
        else $error("header byte did not emit exactly one word");

    // Four-word runs only come from a completed TTL or a flush at the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        bundle.count == 3'd4 |-> phase_reg == PH_FIXED
            && (fo_reg == TTL_LAST || (fo_reg == 4'd6 && item_reg.pkt_last)))
        else $error("four-word run outside TTL release or flush");

    // A status other than fresh only goes out with the message end
    assert property (@(posedge clk) disable iff (!rst_n)
        bundle.status != ST_FRESH |-> bundle.msg_last && bundle.count != 3'd0)
        else $error("status raised away from message end");

endmodule

// ===== design/dttl_outq.sv =====
// Result queue: takes up to four words per cycle from the walker and hands
// them out one per cycle while the result channel is ready. Uses dttl_pkg, dttl_out_if.
module dttl_outq #(
    parameter int DEPTH = dttl_pkg::OUTQ_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dttl_pkg::bundle_t bundle,
    output logic              space_ok,
    dttl_out_if.source        res
);
    import dttl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t             mem [DEPTH];
    word_t             wr_word [MAX_RUN];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    word_t             head;

    // Room for a full run is judged on the registered fill level
    assign space_ok = count_reg <= CNT_W'(DEPTH - MAX_RUN);
    assign pop      = res.valid && res.ready;

    // Build the words of this run; only the last one carries run markers
    always_comb
    begin
        for (int k = 0; k < MAX_RUN; k++)
        begin
            wr_word[k].out_byte       = bundle.bytes[k];
            wr_word[k].run_end        = (bundle.count == 3'(k + 1));
            wr_word[k].message_end    = wr_word[k].run_end && bundle.msg_last;
            wr_word[k].message_status = wr_word[k].message_end ? bundle.status : ST_FRESH;
        end
    end

    // Pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(bundle.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(bundle.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RUN; k++)
        begin
            if (3'(k) < bundle.count)
            begin
                mem[wr_ptr_reg + PTR_W'(k)] <= wr_word[k];
            end
        end
    end

    // Head of queue drives the channel
    assign head               = mem[rd_ptr_reg];
    assign res.valid          = count_reg != '0;
    assign res.out_byte       = head.out_byte;
    assign res.run_end        = head.run_end;
    assign res.message_end    = head.message_end;
    assign res.message_status = head.message_status;

    // Fill level never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // The walker only writes when a full run fits
    assert property (@(posedge clk) disable iff (!rst_n)
        bundle.count != 3'd0 |-> space_ok)
        else $error("run written without room");

    // Fill level tracks writes and reads
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(bundle.count))
                              - CNT_W'($past(pop)))
        else $error("fill level out of step");

    // A message end word always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.message_end |-> res.run_end)
        else $error("message end without run end");

endmodule

// ===== design/dns_record_ttl_aging_rewriter.sv =====
// DNS record TTL ageing rewriter, top level. Depends on dttl_pkg, dttl_in_if,
// dttl_out_if, dttl_parse and dttl_outq.
//
// Takes a cached DNS message one byte a word and passes it through, replacing
// the TTL of each resource record by its aged value (OPT records untouched).
// One input word is accepted per cycle while pkt.ready is high, back to back;
// an accepted byte goes through the input register, then the result queue. The
// three leading TTL bytes of a record give no word; the fourth gives a run of
// four. A final byte that cuts a TTL short gives the held bytes and itself as one
// run. pkt.ready falls only while the result queue (OUTQ_DEPTH words, a power of
// two of at least 8) has fewer than four free entries, so input stalls only when
// the result side is stalled. message_status is valid on the message_end word.
module dns_record_ttl_aging_rewriter #(
    parameter int OUTQ_DEPTH = dttl_pkg::OUTQ_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dttl_in_if.sink    pkt,
    dttl_out_if.source res
);
    import dttl_pkg::*;

    item_t   pkt_item;
    bundle_t bundle;
    logic    space_ok;

    // Gather the input payload
    always_comb
    begin
        pkt_item.pkt_byte     = pkt.pkt_byte;
        pkt_item.pkt_last     = pkt.pkt_last;
        pkt_item.stored_time  = pkt.stored_time;
        pkt_item.current_time = pkt.current_time;
    end

    dttl_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt.valid),
        .in_item  (pkt_item),
        .in_ready (pkt.ready),
        .space_ok (space_ok),
        .bundle   (bundle)
    );

    dttl_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .bundle   (bundle),
        .space_ok (space_ok),
        .res      (res)
    );

endmodule
